[design/selective_repeat_receiver_assert.svh]
// Assertion macros for the selective-repeat receiver.
`ifndef SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold in every cycle out of reset.
`define SRR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("selective_repeat_receiver: assertion failed");
// Condition in one cycle implies a consequence in the next cycle.
`define SRR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("selective_repeat_receiver: assertion failed");
`else
`define SRR_ASSERT(lbl, prop)
`define SRR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/srr_pkg.sv]
// Shared types and constants of the selective-repeat receiver.
`timescale 1ns / 1ps

package srr_pkg;

    // Reorder window depth; a power of two, the slot is the low bits of the sequence number.
    localparam int REORDER_DEPTH = 16;
    localparam int SLOT_W        = $clog2(REORDER_DEPTH);
    localparam int PAYLOAD_WIDTH = 32;
    localparam int SEQ_W         = 16;

    typedef logic [SEQ_W-1:0]         seq_t;
    typedef logic [SLOT_W-1:0]        slot_t;
    typedef logic [REORDER_DEPTH-1:0] slot_vec_t;
    typedef logic [PAYLOAD_WIDTH-1:0] pay_t;

    typedef struct packed {
        logic [15:0] seq_num;
        logic        checksum_ok;
        logic [31:0] payload;
    } pkt_t;

    typedef struct packed {
        logic        is_delivery;
        logic [15:0] seq_out;
        logic        ack_ok;
        logic        duplicate;
        logic        out_of_window;
        logic [31:0] data_out;
        logic        transfer_done;
        logic        last;
    } res_t;

    // Slot buffer control from the sequencer.
    typedef struct packed {
        logic  wr_en;
        slot_t wr_addr;
        logic  clr_en;
        slot_t clr_addr;
        logic  rd_en;
        slot_t rd_addr;
    } buf_ctrl_t;

endpackage

[design/srr_slot_buf.sv]
// Reorder slot store: valid flags in flops, payload words in a small memory.
`timescale 1ns / 1ps

module srr_slot_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  srr_pkg::buf_ctrl_t ctrl,
    input  srr_pkg::pay_t     wr_data,
    output srr_pkg::slot_vec_t valid,
    output srr_pkg::pay_t     rd_data
);

    srr_pkg::slot_vec_t valid_reg;
    srr_pkg::slot_vec_t valid_next;
    srr_pkg::pay_t      mem [srr_pkg::REORDER_DEPTH];
    srr_pkg::pay_t      rd_data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clr_en)
        begin
            valid_next[ctrl.clr_addr] = 1'b0;
        end
        if (ctrl.wr_en)
        begin
            valid_next[ctrl.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign valid   = valid_reg;
    assign rd_data = rd_data_reg;

endmodule

[design/selective_repeat_receiver.sv]
// Top level of the selective-repeat receiver: sequencer, result register, config.
`timescale 1ns / 1ps
`include "selective_repeat_receiver_assert.svh"

// Selective-repeat receiver. Each packet request yields one acknowledgement
// result (sequence number, checksum status, duplicate and out-of-window flags),
// followed by in-order deliveries of the contiguous held payloads from the
// expected sequence number onward; last marks the final result of a packet.
// Sequence 0 is the header: acknowledged, advances the expected number, and
// releases anything already held. Packets beyond the 16-slot reorder window
// are flagged and dropped. Timing: the acknowledgement is loaded the cycle the
// packet is taken; each delivery then takes a registered payload memory read
// (S_READ) and then a result load (S_EMIT), which waits while the result side
// stalls; a packet has up to 16 deliveries. The next packet is taken once the
// sequencer is idle and the result register is free. total_packets is written
// through the cfg port while idle; transfer_done reports expected number ==
// total_packets.
module selective_repeat_receiver (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pkt_valid,
    output logic          pkt_stall,
    input  srr_pkg::pkt_t pkt,
    output logic          res_valid,
    input  logic          res_stall,
    output srr_pkg::res_t res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a packet
    localparam logic [1:0] S_READ = 2'd1;  // payload read of the expected slot
    localparam logic [1:0] S_EMIT = 2'd2;  // delivery result load

    localparam logic [srr_pkg::SLOT_W:0] WIN = (srr_pkg::SLOT_W + 1)'(srr_pkg::REORDER_DEPTH);

    logic [1:0]          state_reg, state_next;
    srr_pkg::seq_t       exp_reg, exp_next;
    logic [15:0]         total_reg;
    logic                res_valid_reg, res_valid_next;
    srr_pkg::res_t       res_reg, res_next;

    srr_pkg::buf_ctrl_t  bctl;
    srr_pkg::slot_vec_t  slot_valid;
    srr_pkg::pay_t       rd_data;

    logic                res_free;
    logic                pkt_acc;

    // acknowledgement decode
    srr_pkg::seq_t       diff;
    srr_pkg::slot_t      pkt_slot;
    logic                below, in_win, dup, oow, take, hdr, drain;
    srr_pkg::seq_t       exp_ack;
    srr_pkg::slot_vec_t  valid_ack;

    // delivery step
    srr_pkg::slot_t      exp_slot;
    srr_pkg::seq_t       exp_inc;
    srr_pkg::slot_vec_t  valid_dlv;
    logic                more;

    srr_slot_buf u_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (bctl),
        .wr_data (srr_pkg::pay_t'(pkt.payload)),
        .valid   (slot_valid),
        .rd_data (rd_data)
    );

    assign res_free  = !res_valid_reg || !res_stall;
    assign pkt_stall = !((state_reg == S_IDLE) && res_free);
    assign pkt_acc   = pkt_valid && !pkt_stall;
    assign cfg_ready = (state_reg == S_IDLE);

    // Window classification of the arriving packet.
    always_comb
    begin
        below     = pkt.seq_num < exp_reg;
        diff      = pkt.seq_num - exp_reg;
        in_win    = !below &&
                    ({1'b0, diff[srr_pkg::SEQ_W-1:0]} <
                     {{(srr_pkg::SEQ_W - srr_pkg::SLOT_W){1'b0}}, WIN});
        pkt_slot  = pkt.seq_num[srr_pkg::SLOT_W-1:0];
        dup       = below || (in_win && slot_valid[pkt_slot]);
        oow       = !below && !in_win;
        take      = pkt.checksum_ok && !dup && !oow;
        hdr       = (pkt.seq_num == '0);
        exp_ack   = (take && hdr) ? exp_reg + 1'b1 : exp_reg;
        valid_ack = slot_valid;
        if (take && !hdr)
        begin
            valid_ack[pkt_slot] = 1'b1;
        end
        drain     = take && valid_ack[exp_ack[srr_pkg::SLOT_W-1:0]];
    end

    // Next-slot lookahead for a delivery.
    always_comb
    begin
        exp_slot            = exp_reg[srr_pkg::SLOT_W-1:0];
        exp_inc             = exp_reg + 1'b1;
        valid_dlv           = slot_valid;
        valid_dlv[exp_slot] = 1'b0;
        more                = valid_dlv[exp_inc[srr_pkg::SLOT_W-1:0]];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;

        bctl           = '0;
        bctl.wr_addr   = pkt_slot;
        bctl.clr_addr  = exp_slot;
        bctl.rd_addr   = exp_slot;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pkt_acc)
                begin
                    res_next.is_delivery   = 1'b0;
                    res_next.seq_out       = pkt.seq_num;
                    res_next.ack_ok        = pkt.checksum_ok;
                    res_next.duplicate     = dup;
                    res_next.out_of_window = oow;
                    res_next.data_out      = '0;
                    res_next.transfer_done = (exp_reg == total_reg);
                    res_next.last          = !drain;
                    res_valid_next         = 1'b1;
                    bctl.wr_en             = take && !hdr;
                    exp_next               = exp_ack;
                    if (drain)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                bctl.rd_en = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    res_next.is_delivery   = 1'b1;
                    res_next.seq_out       = exp_reg;
                    res_next.ack_ok        = 1'b0;
                    res_next.duplicate     = 1'b0;
                    res_next.out_of_window = 1'b0;
                    res_next.data_out      = 32'(rd_data);
                    res_next.transfer_done = (exp_inc == total_reg);
                    res_next.last          = !more;
                    res_valid_next         = 1'b1;
                    bctl.clr_en            = 1'b1;
                    exp_next               = exp_inc;
                    state_next             = more ? S_READ : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            exp_reg       <= '0;
            total_reg     <= 16'd1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                total_reg <= cfg_data;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // An accepted packet puts its acknowledgement up next cycle.
    `SRR_ASSERT_NEXT(a_ack_follows, pkt_valid && !pkt_stall, res_valid && !res.is_delivery)
    // No new packet while results of the previous one are still pending.
    `SRR_ASSERT(a_no_overlap, !(res_valid && !res.last && !pkt_stall))
    // A delivery load carries the expected number it consumed.
    `SRR_ASSERT_NEXT(a_dlv_seq, state_reg == S_EMIT && res_free,
                     res_valid && res.is_delivery && res.seq_out == $past(exp_reg))

endmodule

[tb/srr_checker.sv]
// Checker for the selective-repeat receiver: predicts every result and compares it.
`timescale 1ns / 1ps

module srr_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pkt_valid,
    input  logic          pkt_stall,
    input  srr_pkg::pkt_t pkt,
    input  logic          res_valid,
    input  logic          res_stall,
    input  srr_pkg::res_t res,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [15:0]   cfg_data,
    output int            errors,
    output int            outstanding
);

    srr_pkg::seq_t      next_seq;
    srr_pkg::seq_t      total;
    srr_pkg::slot_vec_t held;
    srr_pkg::pay_t      stash [srr_pkg::REORDER_DEPTH];
    srr_pkg::res_t      awaited [$];
    int                 fail_n = 0;
    int                 shown  = 0;

    function automatic string show(input srr_pkg::res_t r);
        return $sformatf("dlv=%0b seq=%0d ok=%0b dup=%0b oow=%0b data=%h done=%0b last=%0b",
                         r.is_delivery, r.seq_out, r.ack_ok, r.duplicate, r.out_of_window,
                         r.data_out, r.transfer_done, r.last);
    endfunction

    task automatic flag(input string msg);
        fail_n++;
        if (shown < 10)
        begin
            $display("%0t srr_checker: %s", $time, msg);
            shown++;
        end
    endtask

    // Ack first, then every contiguous held payload from next_seq on.
    task automatic predict_packet(input srr_pkg::pkt_t p);
        srr_pkg::res_t  r;
        srr_pkg::res_t  batch [$];
        logic           below;
        logic           in_win;
        logic           dup;
        logic           oow;
        srr_pkg::slot_t s;
        below  = p.seq_num < next_seq;
        in_win = !below && (int'(p.seq_num) - int'(next_seq)) < srr_pkg::REORDER_DEPTH;
        s      = p.seq_num[srr_pkg::SLOT_W-1:0];
        dup    = below || (in_win && held[s]);
        oow    = !below && !in_win;
        r               = '0;
        r.seq_out       = p.seq_num;
        r.ack_ok        = p.checksum_ok;
        r.duplicate     = dup;
        r.out_of_window = oow;
        r.transfer_done = (next_seq == total);
        batch = {batch, r};
        if (p.checksum_ok && !dup && !oow)
        begin
            if (p.seq_num == '0)
                next_seq = next_seq + 1'b1;
            else
            begin
                held[s]  = 1'b1;
                stash[s] = p.payload;
            end
            while (held[next_seq[srr_pkg::SLOT_W-1:0]])
            begin
                r             = '0;
                r.is_delivery = 1'b1;
                r.seq_out     = next_seq;
                r.data_out    = stash[next_seq[srr_pkg::SLOT_W-1:0]];
                held[next_seq[srr_pkg::SLOT_W-1:0]] = 1'b0;
                next_seq      = next_seq + 1'b1;
                r.transfer_done = (next_seq == total);
                batch = {batch, r};
            end
        end
        foreach (batch[i])
        begin
            r      = batch[i];
            r.last = (i == batch.size() - 1);
            awaited = {awaited, r};
        end
    endtask

    task automatic check_result(input srr_pkg::res_t got);
        srr_pkg::res_t want;
        if (awaited.size() == 0)
        begin
            flag({"result with nothing pending: ", show(got)});
            return;
        end
        want = awaited.pop_front();
        if (got.is_delivery !== want.is_delivery || got.seq_out !== want.seq_out ||
            got.ack_ok !== want.ack_ok || got.duplicate !== want.duplicate ||
            got.out_of_window !== want.out_of_window || got.data_out !== want.data_out ||
            got.transfer_done !== want.transfer_done || got.last !== want.last)
            flag({"expected ", show(want), " got ", show(got)});
    endtask

    // Requests are taken before results so a same-edge pass-through still lines up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_seq = '0;
            total    = 16'd1;
            held     = '0;
            awaited.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                total = cfg_data;
            if (pkt_valid && !pkt_stall)
                predict_packet(pkt);
            if (res_valid && !res_stall)
                check_result(res);
        end
        errors      <= fail_n;
        outstanding <= awaited.size();
    end

endmodule

[tb/tb_selective_repeat_receiver.sv]
// Testbench top for the selective-repeat receiver: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_selective_repeat_receiver;

    // Cycles without any accepted request on any channel before giving up.
    localparam int QUIET_LIMIT = 2000;
    // Margin above one packet's worth of work: the ack plus sixteen deliveries.
    localparam int DRAIN_CYCLES = 40;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          pkt_valid = 1'b0;
    logic          pkt_stall;
    srr_pkg::pkt_t pkt       = '0;
    logic          res_valid;
    logic          res_stall = 1'b0;
    srr_pkg::res_t res;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [15:0]   cfg_data  = '0;

    int errors;
    int outstanding;

    // Percent chance per cycle that the sender idles / the result side stalls.
    int send_idle = 0;
    int stall_pct = 0;

    // Next sequence number the receiver will expect once the current block is complete.
    int base  = 0;
    int items = 0;
    int quiet = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    selective_repeat_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    srr_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt_valid   (pkt_valid),
        .pkt_stall   (pkt_stall),
        .pkt         (pkt),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Result-side back-pressure, redrawn every cycle.
    always @(negedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: any accepted request on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pkt_valid && !pkt_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // One packet request. Valid only drops at the next negedge if another
    // request does not follow, so it is never lowered and raised in one step.
    task automatic send_pkt(input srr_pkg::seq_t s, input logic ok, input srr_pkg::pay_t d);
        srr_pkg::pkt_t p;
        p.seq_num     = s;
        p.checksum_ok = ok;
        p.payload     = d;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            pkt_valid <= 1'b0;
            @(negedge clk);
        end
        pkt_valid <= 1'b1;
        pkt       <= p;
        do
            @(posedge clk);
        while (pkt_stall);
        items++;
    endtask

    // Drop valid and wait until every predicted result has been taken,
    // then let the block run out its internal pipeline if asked.
    task automatic settle(input int extra);
        @(negedge clk);
        pkt_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_total(input logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A window-sized block base..base+k-1 in shuffled order, i.e. what a
    // selective-repeat sender produces after losses and retransmissions.
    // With base_last the head packet comes last, so the whole block drains
    // on one request. Noise requests never store anything, so the block
    // always leaves the receiver expecting base+k.
    task automatic send_block(input int k, input bit base_last, input bit noisy);
        srr_pkg::seq_t order [$];
        srr_pkg::seq_t tmp;
        int            j;
        int            r;
        for (int i = 0; i < k; i++)
            order.insert(order.size(), srr_pkg::seq_t'(base + i));
        for (int i = k - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        if (base_last)
        begin
            for (int i = 0; i < k - 1; i++)
            begin
                if (order[i] == srr_pkg::seq_t'(base))
                begin
                    order[i]     = order[k-1];
                    order[k-1]   = srr_pkg::seq_t'(base);
                end
            end
        end
        for (int i = 0; i < k; i++)
        begin
            r = noisy ? int'($urandom_range(99)) : 99;
            if (r < 8)                      // corrupted copy
                send_pkt(order[i], 1'b0, $urandom());
            else if (r < 14 && base > 0)    // stale retransmission, already delivered
                send_pkt(srr_pkg::seq_t'($urandom_range(base - 1)), 1'b1, $urandom());
            else if (r < 20)                // far ahead of the window
                send_pkt(srr_pkg::seq_t'($urandom_range(65535, base + 32)), 1'b1, $urandom());
            else if (r < 26 && i > 0)       // resend of something from this block
                send_pkt(order[$urandom_range(i - 1)], 1'b1, $urandom());
            else if (r < 30)                // line garbage, checksum fails
                send_pkt(srr_pkg::seq_t'($urandom()), 1'b0, $urandom());
            send_pkt(order[i], 1'b1, $urandom());
        end
        base += k;
    endtask

    initial
    begin
        int          send_pcts  [4];
        int          stall_pcts [4];
        logic [15:0] tot;
        bit          first;

        send_pcts  = '{0, 58, 0, 20};
        stall_pcts = '{0, 0, 58, 20};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: window edges, bad checksums, duplicates, header handling.
        set_total(16'd4);
        send_pkt(16'd3, 1'b1, 32'hFFFF_FFFF);  // held before the header arrives
        send_pkt(16'd2, 1'b0, 32'h0000_0000);  // bad checksum, not stored
        send_pkt(16'd16, 1'b1, 32'h1111_1111); // first number past the window
        send_pkt(16'hFFFF, 1'b1, 32'h0000_0000);
        send_pkt(16'd1, 1'b1, 32'h0000_0000);
        send_pkt(16'd1, 1'b1, 32'h1234_5678);  // slot already held
        send_pkt(16'd0, 1'b0, 32'h2222_2222);  // header with bad checksum
        send_pkt(16'd0, 1'b1, 32'hA5A5_A5A5);  // header: releases seq 1 at once
        send_pkt(16'd0, 1'b1, 32'h3333_3333);  // header again, now below expected
        send_pkt(16'd2, 1'b1, 32'h5A5A_5A5A);  // releases 2 and 3, reaches total
        send_pkt(16'd5, 1'b1, 32'h4444_4444);
        send_pkt(16'd4, 1'b1, 32'h5555_5555);  // releases 4 and 5
        send_pkt(16'd21, 1'b1, 32'h6666_6666); // last number inside the window
        send_pkt(16'd22, 1'b1, 32'h7777_7777); // first number outside it
        send_pkt(16'd19, 1'b1, 32'h8888_8888);
        base = 6;

        // Random blocks under four idling mixes, a new total for each.
        for (int phase = 0; phase < 4; phase++)
        begin
            settle(DRAIN_CYCLES);
            case (phase)
                0: tot = srr_pkg::seq_t'(base + $urandom_range(10, 40));
                1: tot = 16'd1;
                2: tot = srr_pkg::seq_t'($urandom_range(2, 65534));
                default: tot = srr_pkg::seq_t'(base + $urandom_range(10, 40));
            endcase
            set_total(tot);
            send_idle = send_pcts[phase];
            stall_pct = stall_pcts[phase];
            items     = 0;
            first     = 1'b1;
            while (items < 50)
            begin
                // First block of each phase fills the window and drains it in one go.
                send_block(first ? 16 : int'($urandom_range(1, 16)),
                           first || ($urandom_range(3) == 0), 1'b1);
                // Sender holds off until every pending result is out.
                if (first || $urandom_range(4) == 0)
                    settle(0);
                first = 1'b0;
            end
        end

        settle(DRAIN_CYCLES);
        if (errors == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
